@@ design/arxsh_pkg.sv @@
package arxsh_pkg;

  localparam int unsigned WORDS         = 32;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATE_W       = WORDS * WORD_W;
  localparam int unsigned BLOCK_BYTES   = 32;
  localparam int unsigned BLOCK_W       = BLOCK_BYTES * 8;
  localparam int unsigned BLOCK_ROUNDS  = 16;
  localparam int unsigned INIT_ROUNDS_3 = 16;
  localparam int unsigned FINAL_ROUNDS_3 = 32;
  localparam int unsigned ROUNDS_2      = 160;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned IN_W          = 264;
  localparam int unsigned OUT_W         = 72;
  localparam int unsigned HB_W          = 7;
  localparam int unsigned MAX_HASH_BYTES = 64;
  localparam logic [7:0]  PAD_BYTE      = 8'h80;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WORDS-1:0] state_t;

  typedef enum logic {
    CFG_REVISION  = 1'b0,
    CFG_HASH_BYTES = 1'b1
  } cfg_reg_t;

  function automatic logic [HB_W-1:0] eff_hash_bytes(input logic [HB_W-1:0] hb);
    logic [HB_W-1:0] r;
    if (hb == '0) begin
      r = HB_W'(1);
    end else if (hb > HB_W'(MAX_HASH_BYTES)) begin
      r = HB_W'(MAX_HASH_BYTES);
    end else begin
      r = hb;
    end
    return r;
  endfunction

endpackage

@@ design/arx_sponge_hash_engine_unit.sv @@
// CubeHash engine with 32-byte blocks and 16 rounds per block. One shared round
// unit runs a full round per clock under a small sequencer. A block request is
// accepted in the idle state and then runs 16 rounds before the next block can
// be taken. The first block of a message adds 16 initial rounds (revision 3) or
// 160 (revision 2). The last block adds 16 more rounds if it is a full 32 bytes
// (separate padding block), then 32 final rounds (revision 3) or 160
// (revision 2), then ceil(hash_bytes/8) digest words, one per cycle as
// the output side takes them. in_tready is low while rounds run.
module arx_sponge_hash_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // block_word0 [63:0], block_word1, block_word2, block_word3 [255:192],
  // valid_bytes [261:256], zero fill [263:262]
  input  logic [arxsh_pkg::IN_W-1:0]     in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // digest_word [63:0], word_index [66:64], zero fill [71:67]
  output logic [arxsh_pkg::OUT_W-1:0]    out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int unsigned CW  = arxsh_pkg::CNT_W;
  localparam int unsigned BW  = arxsh_pkg::BLOCK_W;
  localparam int unsigned SW  = arxsh_pkg::STATE_W;
  localparam int unsigned HBW = arxsh_pkg::HB_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_BLOCK,
    S_FINAL,
    S_EMIT
  } fsm_t;

  fsm_t                fsm_r, fsm_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                needs_init_r, needs_init_nxt;
  logic                pad_r, pad_nxt;
  logic                last_r, last_nxt;
  logic [2:0]          k_r, k_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [arxsh_pkg::OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                out_tlast_r, out_tlast_nxt;
  logic                rev_r;
  logic [HBW-1:0]      hb_r;
  arxsh_pkg::state_t   st_r, st_nxt, rnd;
  logic [BW-1:0]       blk_r, blk_nxt;

  logic [BW-1:0]       in_blk, pblk;
  logic [5:0]          in_vb, vb;
  logic                pad_full;
  logic [HBW-1:0]      nbytes;
  logic [2:0]          last_k;
  arxsh_pkg::state_t   init_st;
  logic [63:0]         dig_word;
  logic                cfg_wr;
  logic                emit_load;

  arxsh_round u_round (
    .st_i (st_r),
    .st_o (rnd)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == arxsh_pkg::CFG_HASH_BYTES) ?
                      {{(32 - HBW){1'b0}}, hb_r} : {31'b0, rev_r};

  assign in_tready  = (fsm_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign in_blk = in_tdata[BW-1:0];
  assign in_vb  = in_tdata[BW+5:BW];
  assign vb     = (in_vb > 6'(arxsh_pkg::BLOCK_BYTES)) ? 6'(arxsh_pkg::BLOCK_BYTES) : in_vb;
  assign pad_full = in_tlast && (vb == 6'(arxsh_pkg::BLOCK_BYTES));
  assign nbytes = arxsh_pkg::eff_hash_bytes(hb_r);
  assign last_k = 3'((nbytes - HBW'(1)) >> 3);
  assign emit_load = (fsm_r == S_EMIT) && (!out_tvalid_r || out_tready);

  always_comb begin
    for (int b = 0; b < arxsh_pkg::BLOCK_BYTES; b++) begin
      if (!in_tlast || (vb > 6'(b))) begin
        pblk[8*b +: 8] = in_blk[8*b +: 8];
      end else if (vb == 6'(b)) begin
        pblk[8*b +: 8] = arxsh_pkg::PAD_BYTE;
      end else begin
        pblk[8*b +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    init_st    = '0;
    init_st[0] = arxsh_pkg::word_t'(nbytes);
    init_st[1] = arxsh_pkg::word_t'(arxsh_pkg::BLOCK_BYTES);
    init_st[2] = arxsh_pkg::word_t'(arxsh_pkg::BLOCK_ROUNDS);
  end

  always_comb begin
    dig_word = st_r[{1'b0, k_r, 1'b0} +: 2];
    for (int j = 0; j < 8; j++) begin
      if ({1'b0, k_r, 3'(j)} >= nbytes) begin
        dig_word[8*j +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    fsm_nxt        = fsm_r;
    cnt_nxt        = cnt_r;
    needs_init_nxt = needs_init_r;
    pad_nxt        = pad_r;
    last_nxt       = last_r;
    k_nxt          = k_r;
    st_nxt         = st_r;
    blk_nxt        = blk_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    unique case (fsm_r)
      S_IDLE: begin
        if (in_tvalid) begin
          blk_nxt  = pblk;
          pad_nxt  = pad_full;
          last_nxt = in_tlast;
          if (needs_init_r) begin
            st_nxt         = init_st;
            cnt_nxt        = rev_r ? CW'(arxsh_pkg::ROUNDS_2 - 1) :
                                     CW'(arxsh_pkg::INIT_ROUNDS_3 - 1);
            needs_init_nxt = 1'b0;
            fsm_nxt        = S_INIT;
          end else begin
            st_nxt  = st_r ^ arxsh_pkg::state_t'({{(SW - BW){1'b0}}, pblk});
            cnt_nxt = CW'(arxsh_pkg::BLOCK_ROUNDS - 1);
            fsm_nxt = S_BLOCK;
          end
        end
      end
      S_INIT: begin
        st_nxt  = rnd;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          st_nxt  = rnd ^ arxsh_pkg::state_t'({{(SW - BW){1'b0}}, blk_r});
          cnt_nxt = CW'(arxsh_pkg::BLOCK_ROUNDS - 1);
          fsm_nxt = S_BLOCK;
        end
      end
      S_BLOCK: begin
        st_nxt  = rnd;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          if (pad_r) begin
            st_nxt  = rnd ^ arxsh_pkg::state_t'({{(SW - 8){1'b0}}, arxsh_pkg::PAD_BYTE});
            pad_nxt = 1'b0;
            cnt_nxt = CW'(arxsh_pkg::BLOCK_ROUNDS - 1);
          end else if (last_r) begin
            st_nxt[arxsh_pkg::WORDS-1][0] = ~rnd[arxsh_pkg::WORDS-1][0];
            cnt_nxt = rev_r ? CW'(arxsh_pkg::ROUNDS_2 - 1) :
                              CW'(arxsh_pkg::FINAL_ROUNDS_3 - 1);
            fsm_nxt = S_FINAL;
          end else begin
            fsm_nxt = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        st_nxt  = rnd;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          k_nxt   = '0;
          fsm_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'b0, k_r, dig_word};
          out_tlast_nxt  = (k_r == last_k);
          if (k_r == last_k) begin
            needs_init_nxt = 1'b1;
            fsm_nxt        = S_IDLE;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    st_r        <= st_nxt;
    blk_r       <= blk_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    if (!rst_n) begin
      fsm_r        <= S_IDLE;
      cnt_r        <= '0;
      needs_init_r <= 1'b1;
      pad_r        <= 1'b0;
      last_r       <= 1'b0;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
      rev_r        <= 1'b0;
      hb_r         <= HBW'(arxsh_pkg::MAX_HASH_BYTES);
    end else begin
      fsm_r        <= fsm_nxt;
      cnt_r        <= cnt_nxt;
      needs_init_r <= needs_init_nxt;
      pad_r        <= pad_nxt;
      last_r       <= last_nxt;
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          arxsh_pkg::CFG_REVISION:   rev_r <= cfg_pwdata[0];
          arxsh_pkg::CFG_HASH_BYTES: hb_r  <= cfg_pwdata[HBW-1:0];
          default: ;
        endcase
      end
    end
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("engine ready right after taking a block");

  a_final_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_FINAL && cnt_r == '0) |=> (fsm_r == S_EMIT && k_r == '0))
    else $error("final rounds did not hand over to digest output");

  a_rearm_init: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && k_r == last_k) |=> (needs_init_r && fsm_r == S_IDLE && out_tlast))
    else $error("last digest word did not re-arm initialization");

endmodule

@@ design/arxsh_round.sv @@
module arxsh_round (
  input  arxsh_pkg::state_t st_i,
  output arxsh_pkg::state_t st_o
);

  arxsh_pkg::state_t s0, s1, s2, s3, s4, s5, s6, s7;

  always_comb begin
    s0 = st_i;
    for (int i = 0; i < 16; i++) begin
      s0[i + 16] = st_i[i + 16] + st_i[i];
      s0[i]      = {st_i[i][24:0], st_i[i][31:25]};
    end

    s1 = s0;
    for (int i = 0; i < 16; i++) begin
      s1[i] = s0[i ^ 8] ^ s0[i + 16];
    end

    s2 = s1;
    for (int i = 0; i < 16; i++) begin
      s2[i + 16] = s1[(i ^ 2) + 16];
    end

    s3 = s2;
    for (int i = 0; i < 16; i++) begin
      s3[i + 16] = s2[i + 16] + s2[i];
      s3[i]      = {s2[i][20:0], s2[i][31:21]};
    end

    s4 = s3;
    for (int i = 0; i < 16; i++) begin
      s4[i] = s3[i ^ 4] ^ s3[i + 16];
    end

    s5 = s4;
    for (int i = 0; i < 16; i++) begin
      s5[i + 16] = s4[(i ^ 1) + 16];
    end

    s6 = s5;
    s7 = s6;
    st_o = s7;
  end

endmodule
